[design/gbd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbd_pkg
// Shared types, register indexes, dither tables and sizes for the gradient
// band dither pixel block.
// ----------------------------------------------------------------------------
package gbd_pkg;

   localparam int COORD_WIDTH_DEF = 12;
   localparam int EXT_W           = 13;
   localparam int ORIGIN_W        = 12;
   localparam int COLOR_W         = 24;
   localparam int K_W             = 8;
   localparam int WORD_W          = 16;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 24;
   localparam int QUEUE_DEPTH     = 4;
   localparam int OUT_DEPTH       = 8;
   localparam int DIV_STEPS       = 2;

   localparam logic [CSR_ADDR_W-1:0] REG_COLOR_START = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_COLOR_END   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_VERTICAL    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_DITHER_ON   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_FORMAT_555  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_ORIGIN      = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_EXTENT      = 3'd6;

   // dither patterns indexed by the dropped channel bits, row offsets by y
   localparam logic [7:0] DPAT [8] = '{8'd0, 8'd16, 8'd68, 8'd146,
                                       8'd170, 8'd109, 8'd187, 8'd239};
   localparam logic [2:0] DROW [8] = '{3'd1, 3'd5, 3'd2, 3'd7,
                                       3'd4, 3'd0, 3'd6, 3'd3};

   typedef struct packed {
      logic [COLOR_W-1:0]  color_start;
      logic [COLOR_W-1:0]  color_end;
      logic                vertical;
      logic                dither_on;
      logic                format_555;
      logic [ORIGIN_W-1:0] origin;
      logic [EXT_W-1:0]    extent;
   } gbd_cfg_type;

   localparam gbd_cfg_type CFG_RESET = '{
      color_start: 24'd0,
      color_end:   24'd0,
      vertical:    1'b0,
      dither_on:   1'b1,
      format_555:  1'b0,
      origin:      12'd0,
      extent:      13'd256
   };

   typedef struct packed {
      logic       flag;
      logic [2:0] px_lo;
      logic [2:0] py_lo;
   } gbd_tag_type;

   typedef struct packed {
      logic [EXT_W-1:0] off;
      gbd_tag_type      tag;
   } gbd_item_type;

   typedef struct packed {
      logic [WORD_W-1:0] pixel_word;
      logic              out_of_span;
   } gbd_rsp_type;

   // a zero extent counts as one pixel
   function automatic logic [EXT_W-1:0] ext_of(input logic [EXT_W-1:0] extent);
      return (extent == '0) ? EXT_W'(1) : extent;
   endfunction

endpackage

[design/gbd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbd_fifo
// Small register queue with occupancy count; depth is a power of two.
// ----------------------------------------------------------------------------
module gbd_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wdata,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rdata,
   output logic                       full,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata = mem_ff[rd_ptr_ff];
   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign count = count_ff;

endmodule

[design/gbd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbd_front
// Takes pixel beats, finds the clamped axis offset and span flag, and queues
// them for the back end.
// ----------------------------------------------------------------------------
module gbd_front import gbd_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gbd_cfg_type            cfg,
   input  logic                   push,
   output logic                   full,
   input  logic [COORD_WIDTH-1:0] pix_x,
   input  logic [COORD_WIDTH-1:0] pix_y,
   input  logic                   q_pop,
   output gbd_item_type           q_item,
   output logic                   q_empty
);

   localparam int WIDE = (COORD_WIDTH > EXT_W) ? COORD_WIDTH : EXT_W;

   logic [COORD_WIDTH-1:0] coord;
   logic [WIDE-1:0]        coord_w;
   logic [WIDE-1:0]        origin_w;
   logic [WIDE-1:0]        ext_w;
   logic [WIDE-1:0]        diff;
   logic [EXT_W-1:0]       ext;
   logic                   before_org;
   logic                   past_end;
   logic                   accept;
   gbd_item_type           item;

   always_comb begin
      coord      = cfg.vertical ? pix_y : pix_x;
      coord_w    = WIDE'(coord);
      origin_w   = WIDE'(cfg.origin);
      ext        = ext_of(cfg.extent);
      ext_w      = WIDE'(ext);
      diff       = coord_w - origin_w;
      before_org = (coord_w < origin_w);
      past_end   = !before_org && (diff >= ext_w);

      if (before_org) begin
         item.off = '0;
      end else if (past_end) begin
         item.off = ext - EXT_W'(1);
      end else begin
         item.off = diff[EXT_W-1:0];
      end
      item.tag.flag  = before_org | past_end;
      item.tag.px_lo = pix_x[2:0];
      item.tag.py_lo = pix_y[2:0];
   end

   assign accept = push && !full;

   gbd_fifo #(
      .WIDTH ($bits(gbd_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (accept),
      .wdata (item),
      .pop   (q_pop),
      .rdata (q_item),
      .full  (full),
      .empty (q_empty),
      .count ()
   );

endmodule

[design/gbd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbd_back
// Band index by pipelined restoring division, channel blend, ordered dither
// and packing, then a result queue sized so the pipeline never stalls.
// ----------------------------------------------------------------------------
module gbd_back import gbd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  gbd_cfg_type       cfg,
   input  gbd_item_type      q_item,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [WORD_W-1:0] rsp_pixel_word,
   output logic              rsp_out_of_span
);

   localparam int DIV_STAGES = K_W / DIV_STEPS;
   localparam int PIPE       = DIV_STAGES + 1;
   localparam int OCW        = $clog2(OUT_DEPTH + 1);

   // one quotient bit: the dividend's low byte is all ones
   function automatic logic [EXT_W:0] div_step(input logic [EXT_W-1:0] rem,
                                               input logic [EXT_W-1:0] d);
      logic [EXT_W:0] t;
      logic           ge;
      t  = {rem, 1'b1};
      ge = (t >= {1'b0, d});
      if (ge) begin
         t = t - {1'b0, d};
      end
      return {ge, t[EXT_W-1:0]};
   endfunction

   logic [EXT_W-1:0]   ext;
   logic [PIPE-1:0]    vld_ff, vld_in;
   logic [EXT_W-1:0]   src_rem [DIV_STAGES];
   logic [K_W-1:0]     src_quo [DIV_STAGES];
   gbd_tag_type        src_tag [DIV_STAGES];
   logic [EXT_W-1:0]   rem_ff  [DIV_STAGES];
   logic [EXT_W-1:0]   rem_in  [DIV_STAGES];
   logic [K_W-1:0]     quo_ff  [DIV_STAGES];
   logic [K_W-1:0]     quo_in  [DIV_STAGES];
   gbd_tag_type        tag_ff  [DIV_STAGES];
   logic signed [17:0] prod_ff [3];
   logic signed [17:0] prod_in [3];
   logic [2:0]         pr_ff, pr_in;
   logic               flag_ff;
   logic [7:0]         chan [3];
   logic [2:0]         pb, pg;
   logic               bit_r, bit_b, bit_g5, bit_g6;
   logic [5:0]         qr, qb, qg5;
   logic [6:0]         qg6;
   logic [4:0]         qr_c, qb_c, qg5_c;
   logic [5:0]         qg6_c;
   gbd_rsp_type        rsp_in;
   gbd_rsp_type        rsp_out;
   logic [OCW-1:0]     out_count;
   logic [OCW:0]       inflight;
   logic               issue;

   assign ext = ext_of(cfg.extent);

   // issue only when the result queue has room for everything in flight
   always_comb begin
      inflight = '0;
      for (int i = 0; i < PIPE; i++) begin
         inflight = inflight + (OCW+1)'(vld_ff[i]);
      end
      issue = !q_empty && (((OCW+1)'(out_count) + inflight) < (OCW+1)'(OUT_DEPTH));
   end

   assign q_pop = issue;

   always_comb begin
      vld_in[0] = issue;
      for (int i = 1; i < PIPE; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // division stages
   always_comb begin
      src_rem[0] = q_item.off;
      src_quo[0] = '0;
      src_tag[0] = q_item.tag;
      for (int i = 1; i < DIV_STAGES; i++) begin
         src_rem[i] = rem_ff[i-1];
         src_quo[i] = quo_ff[i-1];
         src_tag[i] = tag_ff[i-1];
      end
   end

   always_comb begin
      logic [EXT_W-1:0] step;
      logic [EXT_W:0]   st;
      logic [K_W-1:0]   quo;
      for (int i = 0; i < DIV_STAGES; i++) begin
         step = src_rem[i];
         quo  = src_quo[i];
         for (int j = 0; j < DIV_STEPS; j++) begin
            st   = div_step(step, ext);
            quo  = {quo[K_W-2:0], st[EXT_W]};
            step = st[EXT_W-1:0];
         end
         rem_in[i] = step;
         quo_in[i] = quo;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
         rem_ff[i] <= rem_in[i];
         quo_ff[i] <= quo_in[i];
         tag_ff[i] <= src_tag[i];
      end
   end

   // blend products: k * (end - start) per channel
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         prod_in[c] = $signed({1'b0, quo_ff[DIV_STAGES-1]}) *
                      ($signed({1'b0, cfg.color_end[8*c +: 8]}) -
                       $signed({1'b0, cfg.color_start[8*c +: 8]}));
      end
      pr_in = 3'(tag_ff[DIV_STAGES-1].px_lo + DROW[tag_ff[DIV_STAGES-1].py_lo]);
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         prod_ff[c] <= prod_in[c];
      end
      pr_ff   <= pr_in;
      flag_ff <= tag_ff[DIV_STAGES-1].flag;
   end

   // channel value, dither and pack
   always_comb begin
      logic signed [17:0] num;
      for (int c = 0; c < 3; c++) begin
         num     = $signed({2'b00, cfg.color_start[8*c +: 8], 8'h00}) + prod_ff[c];
         chan[c] = num[15:8];
      end
      pb     = 3'(pr_ff + 3'd3);
      pg     = 3'(pr_ff + 3'd2);
      bit_r  = DPAT[chan[0][2:0]][pr_ff];
      bit_b  = DPAT[chan[2][2:0]][pb];
      bit_g5 = DPAT[chan[1][2:0]][pg];
      bit_g6 = DPAT[{chan[1][1:0], 1'b0}][pg];
      qr     = {1'b0, chan[0][7:3]} + 6'(bit_r);
      qb     = {1'b0, chan[2][7:3]} + 6'(bit_b);
      qg5    = {1'b0, chan[1][7:3]} + 6'(bit_g5);
      qg6    = {1'b0, chan[1][7:2]} + 7'(bit_g6);
      // clamp on carry out
      qr_c   = qr[5]  ? 5'd31 : qr[4:0];
      qb_c   = qb[5]  ? 5'd31 : qb[4:0];
      qg5_c  = qg5[5] ? 5'd31 : qg5[4:0];
      qg6_c  = qg6[6] ? 6'd63 : qg6[5:0];

      if (!cfg.dither_on) begin
         rsp_in.pixel_word = {chan[0][7:3], chan[1][7:2], chan[2][7:3]};
      end else if (cfg.format_555) begin
         rsp_in.pixel_word = {1'b0, qr_c, qg5_c, qb_c};
      end else begin
         rsp_in.pixel_word = {qr_c, qg6_c, qb_c};
      end
      rsp_in.out_of_span = flag_ff;
   end

   gbd_fifo #(
      .WIDTH ($bits(gbd_rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock (clock),
      .reset (reset),
      .push  (vld_ff[PIPE-1]),
      .wdata (rsp_in),
      .pop   (rsp_pop && !rsp_empty),
      .rdata (rsp_out),
      .full  (),
      .empty (rsp_empty),
      .count (out_count)
   );

   assign rsp_pixel_word  = rsp_out.pixel_word;
   assign rsp_out_of_span = rsp_out.out_of_span;

endmodule

[design/gradient_band_dither_pixel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_band_dither_pixel
// Linear two-colour gradient pixel generator with 8x8 ordered dither.
//
// Input queue: drive req_pix_x/req_pix_y with req_push; a beat is taken on
// a rising edge with req_push high and req_full low. Result queue: while
// rsp_empty is low the oldest result sits on rsp_pixel_word and
// rsp_out_of_span; rsp_pop high takes it. Results leave in input order,
// one per input beat.
// Throughput is one pixel per clock while the receiver keeps up. From an
// accepted beat to its result showing, it passes the input queue, four
// band-division stages (two quotient bits each) and the blend multiply;
// the beat enters the result queue at the end of that and shows at once.
// When the receiver stalls, the 8-entry result queue fills, issue from the
// input queue stops, and req_full rises once the 4-entry input queue is full.
// csr_we/csr_addr/csr_wdata write the configuration registers; change them
// only while no pixel is in flight. Reset empties both queues and loads the
// register defaults (dither on, RGB565, along x, origin 0, extent 256).
// ----------------------------------------------------------------------------
module gradient_band_dither_pixel import gbd_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [COORD_WIDTH-1:0] req_pix_x,
   input  logic [COORD_WIDTH-1:0] req_pix_y,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [WORD_W-1:0]      rsp_pixel_word,
   output logic                   rsp_out_of_span,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   gbd_cfg_type  cfg_ff, cfg_in;
   gbd_item_type q_item;
   logic         q_empty;
   logic         q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_COLOR_START: cfg_in.color_start = csr_wdata[COLOR_W-1:0];
            REG_COLOR_END:   cfg_in.color_end   = csr_wdata[COLOR_W-1:0];
            REG_VERTICAL:    cfg_in.vertical    = csr_wdata[0];
            REG_DITHER_ON:   cfg_in.dither_on   = csr_wdata[0];
            REG_FORMAT_555:  cfg_in.format_555  = csr_wdata[0];
            REG_ORIGIN:      cfg_in.origin      = csr_wdata[ORIGIN_W-1:0];
            REG_EXTENT:      cfg_in.extent      = csr_wdata[EXT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gbd_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .push    (req_push),
      .full    (req_full),
      .pix_x   (req_pix_x),
      .pix_y   (req_pix_y),
      .q_pop   (q_pop),
      .q_item  (q_item),
      .q_empty (q_empty)
   );

   gbd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_item          (q_item),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pixel_word  (rsp_pixel_word),
      .rsp_out_of_span (rsp_out_of_span)
   );

endmodule
